/* src/u8v_pkg.sv */
// shared constants, types and helpers for the utf-8 stream validator
package u8v_pkg;

  localparam int POSITION_BITS = 24;
  localparam int OUT_BITS      = 24;

  localparam logic [POSITION_BITS-1:0] POS_TOP  = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ZERO = {POSITION_BITS{1'b0}};
  localparam logic [POSITION_BITS-1:0] POS_ONE  = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  // second byte narrowing classes
  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_E0   = 3'd1;
  localparam logic [2:0] CLS_ED   = 3'd2;
  localparam logic [2:0] CLS_F0   = 3'd3;
  localparam logic [2:0] CLS_F4   = 3'd4;

  localparam logic [7:0] BYTE_ASCII_TOP = 8'h7F;
  localparam logic [7:0] BYTE_LEAD2_LO  = 8'hC2;
  localparam logic [7:0] BYTE_LEAD2_HI  = 8'hDF;
  localparam logic [7:0] BYTE_E0        = 8'hE0;
  localparam logic [7:0] BYTE_ED        = 8'hED;
  localparam logic [7:0] BYTE_LEAD3_HI  = 8'hEF;
  localparam logic [7:0] BYTE_F0        = 8'hF0;
  localparam logic [7:0] BYTE_F4        = 8'hF4;
  localparam logic [7:0] BYTE_CONT_LO   = 8'h80;
  localparam logic [7:0] BYTE_CONT_HI   = 8'hBF;
  localparam logic [7:0] BYTE_E0_LO     = 8'hA0;
  localparam logic [7:0] BYTE_ED_HI     = 8'h9F;
  localparam logic [7:0] BYTE_F0_LO     = 8'h90;
  localparam logic [7:0] BYTE_F4_HI     = 8'h8F;
  localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;

  // outcome of one byte against the sequence state
  typedef struct packed {
    logic [1:0] pending;
    logic [2:0] cls;
    logic       start;
    logic       bad_lead;
    logic       bad_cont;
  } check_t;

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_TOP) ? v : v + POS_ONE;
  endfunction

  function automatic logic [OUT_BITS-1:0] to_out(input logic [POSITION_BITS-1:0] v);
    logic [OUT_BITS+POSITION_BITS-1:0] wide;
    wide = {{OUT_BITS{1'b0}}, v};
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

/* src/u8v_seq_check.sv */
// byte classification and continuation range check
module u8v_seq_check import u8v_pkg::*; (
  input  logic [7:0] data_byte,
  input  logic [1:0] pending_count,
  input  logic [2:0] second_byte_class,
  output check_t     chk
);

  logic [7:0] lo;
  logic [7:0] hi;

  always_comb begin
    lo = BYTE_CONT_LO;
    hi = BYTE_CONT_HI;
    unique case (second_byte_class)
      CLS_E0:  lo = BYTE_E0_LO;
      CLS_ED:  hi = BYTE_ED_HI;
      CLS_F0:  lo = BYTE_F0_LO;
      CLS_F4:  hi = BYTE_F4_HI;
      default: ;
    endcase
  end

  always_comb begin
    chk = '0;
    if (pending_count == 2'd0) begin
      priority if (data_byte <= BYTE_ASCII_TOP) begin
        chk.pending = 2'd0;
      end else if (data_byte >= BYTE_LEAD2_LO && data_byte <= BYTE_LEAD2_HI) begin
        chk.pending = 2'd1;
      end else if (data_byte == BYTE_E0) begin
        chk.pending = 2'd2;
        chk.cls     = CLS_E0;
      end else if (data_byte == BYTE_ED) begin
        chk.pending = 2'd2;
        chk.cls     = CLS_ED;
      end else if (data_byte > BYTE_E0 && data_byte <= BYTE_LEAD3_HI) begin
        chk.pending = 2'd2;
      end else if (data_byte == BYTE_F0) begin
        chk.pending = 2'd3;
        chk.cls     = CLS_F0;
      end else if (data_byte == BYTE_F4) begin
        chk.pending = 2'd3;
        chk.cls     = CLS_F4;
      end else if (data_byte > BYTE_F0 && data_byte < BYTE_F4) begin
        chk.pending = 2'd3;
      end else begin
        chk.bad_lead = 1'b1;
      end
      chk.start = (chk.pending != 2'd0);
    end else begin
      // narrowing applies to the second byte only, cleared after it
      chk.cls = CLS_NONE;
      if (data_byte >= lo && data_byte <= hi) begin
        chk.pending = pending_count - 2'd1;
      end else begin
        chk.pending  = 2'd0;
        chk.bad_cont = 1'b1;
      end
    end
  end

endmodule

/* src/utf8_stream_validator.sv */
// top level: strict utf-8 check of a byte stream with error position report
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------------
//  input   | in_valid, in_ready  | data_byte, last_byte
//  output  | out_valid, out_ready| is_valid, fault_offset, error_line, error_column
//
// one byte per cycle while in_ready is high; the verdict of a document appears in the
// result register the cycle after its last byte transfers.
// all per-byte work is one pass of classify, range check and counter update.
// rst is synchronous and clears the sequence state and counters to a new document.
// input stalls only while a verdict waits in the result register and out_ready is low.
module utf8_stream_validator import u8v_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                is_valid,
  output logic [OUT_BITS-1:0] fault_offset,
  output logic [OUT_BITS-1:0] error_line,
  output logic [OUT_BITS-1:0] error_column
);

  logic [1:0]               pending_count, pending_count_next;
  logic [2:0]               second_byte_class, second_byte_class_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] line_counter, line_counter_next;
  logic [POSITION_BITS-1:0] column_counter, column_counter_next;
  logic [POSITION_BITS-1:0] lead_position, lead_position_next;
  logic [POSITION_BITS-1:0] lead_line, lead_line_next;
  logic [POSITION_BITS-1:0] lead_column, lead_column_next;
  logic                     error_latched, error_latched_next;
  logic [POSITION_BITS-1:0] saved_error_offset, saved_error_offset_next;
  logic [POSITION_BITS-1:0] saved_error_line, saved_error_line_next;
  logic [POSITION_BITS-1:0] saved_error_column, saved_error_column_next;

  check_t chk;
  logic   in_xfer;

  u8v_seq_check u_check (
    .data_byte         (data_byte),
    .pending_count     (pending_count),
    .second_byte_class (second_byte_class),
    .chk               (chk)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    pending_count_next      = pending_count;
    second_byte_class_next  = second_byte_class;
    lead_position_next      = lead_position;
    lead_line_next          = lead_line;
    lead_column_next        = lead_column;
    error_latched_next      = error_latched;
    saved_error_offset_next = saved_error_offset;
    saved_error_line_next   = saved_error_line;
    saved_error_column_next = saved_error_column;

    if (!error_latched) begin
      pending_count_next     = chk.pending;
      second_byte_class_next = chk.cls;
      if (chk.start) begin
        lead_position_next = byte_position;
        lead_line_next     = line_counter;
        lead_column_next   = column_counter;
      end
      priority if (chk.bad_lead) begin
        error_latched_next      = 1'b1;
        saved_error_offset_next = byte_position;
        saved_error_line_next   = line_counter;
        saved_error_column_next = column_counter;
      end else if (chk.bad_cont) begin
        error_latched_next      = 1'b1;
        saved_error_offset_next = lead_position;
        saved_error_line_next   = lead_line;
        saved_error_column_next = lead_column;
      end else if (last_byte && chk.pending != 2'd0) begin
        // document cut short inside a sequence
        error_latched_next      = 1'b1;
        saved_error_offset_next = lead_position_next;
        saved_error_line_next   = lead_line_next;
        saved_error_column_next = lead_column_next;
      end else begin
      end
    end

    byte_position_next = sat_inc(byte_position);
    if (data_byte == BYTE_NEWLINE) begin
      line_counter_next   = sat_inc(line_counter);
      column_counter_next = POS_ONE;
    end else begin
      line_counter_next   = line_counter;
      column_counter_next = sat_inc(column_counter);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_xfer && last_byte)) begin
      pending_count      <= 2'd0;
      second_byte_class  <= CLS_NONE;
      byte_position      <= POS_ZERO;
      line_counter       <= POS_ONE;
      column_counter     <= POS_ONE;
      lead_position      <= POS_ZERO;
      lead_line          <= POS_ONE;
      lead_column        <= POS_ONE;
      error_latched      <= 1'b0;
      saved_error_offset <= POS_ZERO;
      saved_error_line   <= POS_ZERO;
      saved_error_column <= POS_ZERO;
    end else if (in_xfer) begin
      pending_count      <= pending_count_next;
      second_byte_class  <= second_byte_class_next;
      byte_position      <= byte_position_next;
      line_counter       <= line_counter_next;
      column_counter     <= column_counter_next;
      lead_position      <= lead_position_next;
      lead_line          <= lead_line_next;
      lead_column        <= lead_column_next;
      error_latched      <= error_latched_next;
      saved_error_offset <= saved_error_offset_next;
      saved_error_line   <= saved_error_line_next;
      saved_error_column <= saved_error_column_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last_byte) begin
      is_valid <= !error_latched_next;
      if (error_latched_next) begin
        fault_offset <= to_out(saved_error_offset_next);
        error_line   <= to_out(saved_error_line_next);
        error_column <= to_out(saved_error_column_next);
      end else begin
        fault_offset <= '0;
        error_line   <= '0;
        error_column <= '0;
      end
    end
  end

endmodule
